/* design/rcws_pkg.sv */
package rcws_pkg;

   localparam int WINDOW_SEGMENTS = 1024;
   localparam int MAX_SEGMENT     = 1400;
   localparam int MIN_RTO         = 50;

   localparam int IDX_W     = 32;
   localparam int SEG_W     = 11;
   localparam int RTO_W     = 16;
   localparam int FRAC_W    = 16;
   localparam int WIN_W     = 48;
   localparam int DUP_W     = 8;
   localparam int PROD_W    = IDX_W + SEG_W;
   localparam int SLOT_W    = $clog2(WINDOW_SEGMENTS);
   localparam int DIV_NUM_W = 53;
   localparam int DIV_DEN_W = WIN_W;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
   localparam int CSR_W     = 32;
   localparam int RSP_DATA_W = 112;
   localparam int RSP_USER_W = 5;

   localparam logic [WIN_W-1:0] WIN_MAX        = '1;
   localparam logic [WIN_W-1:0] INIT_THRESH_FX = WIN_W'(64'd65536 << FRAC_W);
   localparam logic [DUP_W-1:0] DUP_MAX        = '1;
   localparam logic [DUP_W-1:0] FAST_RETX_DUPS = DUP_W'(3);

   localparam logic [1:0] CSR_SEGMENT_SIZE    = 2'd0;
   localparam logic [1:0] CSR_RETRANS_TIMEOUT = 2'd1;
   localparam logic [1:0] CSR_TOTAL_LENGTH    = 2'd2;

   typedef enum logic [1:0] {
      KIND_POLL = 2'd0,
      KIND_ACK  = 2'd1,
      KIND_TICK = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_NEW_ACK   = 3'd1,
      EV_DUP_ACK   = 3'd2,
      EV_FAST_RETX = 3'd3,
      EV_TIMEOUT   = 3'd4
   } event_type;

   typedef enum logic [4:0] {
      S_RESTART, S_CLEAR, S_COUNT, S_IDLE, S_MUL, S_OUTST, S_DISPATCH,
      S_FRT, S_RESEND, S_ADIV, S_ADONE, S_ACKUPD, S_RECOV, S_SSMUL, S_SSADD,
      S_CASTART, S_CADIV, S_CAMUL, S_CAADD, S_ACKEND, S_RESULT
   } state_type;

   // sent mark: set for segment tag only while valid and tag matches
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] tag;
   } mark_type;

   localparam int MARK_W = $bits(mark_type);

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic [DIV_NUM_W-1:0] quo;
   } div_rsp_type;

   function automatic logic [WIN_W-1:0] sat_add(input logic [WIN_W-1:0] a,
                                                input logic [WIN_W-1:0] b);
      logic [WIN_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[WIN_W] ? WIN_MAX : sum[WIN_W-1:0];
   endfunction

endpackage

/* design/rcws_ram.sv */
module rcws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* design/rcws_div.sv */
module rcws_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rcws_pkg::div_req_type req,
   output rcws_pkg::div_rsp_type rsp
);
   import rcws_pkg::*;

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   shifted;
   logic [DIV_DEN_W:0]   diff;
   logic                 ge;

   // one quotient bit per cycle, restoring
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_NUM_W-1]};
      diff    = shifted - {1'b0, den_ff};
      ge      = shifted >= {1'b0, den_ff};
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         step_in = DIV_CNT_W'(DIV_NUM_W - 1);
         rem_in  = '0;
         quo_in  = req.num;
         den_in  = req.den;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], ge};
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.quo  = quo_ff;
endmodule

/* design/reno_congestion_window_sender.sv */
// Reno congestion window sender.
// Input stream req_: req_tuser carries the item kind (send poll, cumulative
// ack, one millisecond tick), req_tdata the ack value. Every accepted
// transaction yields exactly one transaction on rsp_: transmission flags and
// event code on rsp_tuser, segment offset and length plus window, threshold,
// recovery and finished status on rsp_tdata, unless a csr_ write restarts first.
// A new ack uses the shared serial divider for the covered segment count and,
// in congestion avoidance, again for the window increment quotient; the
// increment multiply walks 32 bits serially. Sent marks live in a 1024-entry
// memory tagged with the segment index, read on every request and written
// when a poll sends a new segment or a retransmit goes out; a timeout also
// clears the mark after base.
// After reset, and after every csr_ write to one of the three registers, the
// transfer restarts: a clearing pass sweeps all 1024 mark entries while
// req_tready stays low. A new request is taken while a finished result still waits
// in the output register; the block only holds its next result when rsp_tready is low.
module reno_congestion_window_sender (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [31:0]                     req_tdata,  // ack_value
   input  logic [1:0]                      req_tuser,  // kind
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // seg_offset, seg_length, window_bytes, threshold_bytes, in_recovery,
   // finished, zero fill
   output logic [rcws_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // sent, retransmit, event_res
   output logic [rcws_pkg::RSP_USER_W-1:0] rsp_tuser,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [rcws_pkg::CSR_W-1:0]      csr_wdata
);
   import rcws_pkg::*;

   state_type          state_ff, state_in;
   logic [SEG_W-1:0]   seg_size_ff, seg_size_in;
   logic [RTO_W-1:0]   rto_ff, rto_in;
   logic [IDX_W-1:0]   total_ff, total_in;

   logic [WIN_W-1:0]   window_ff, window_in;
   logic [WIN_W-1:0]   thresh_ff, thresh_in;
   logic [IDX_W-1:0]   base_ff, base_in;
   logic [IDX_W-1:0]   next_ff, next_in;
   logic [IDX_W-1:0]   last_ack_ff, last_ack_in;
   logic [DUP_W-1:0]   dup_ff, dup_in;
   logic               recov_ff, recov_in;
   logic               timer_ff, timer_in;
   logic [RTO_W-1:0]   elapsed_ff, elapsed_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;

   kind_type           kind_ff, kind_in;
   logic [IDX_W-1:0]   ack_ff, ack_in;
   logic [PROD_W-1:0]  prod_next_ff, prod_next_in;
   logic [PROD_W-1:0]  prod_base_ff, prod_base_in;
   logic [IDX_W-1:0]   outst_ff, outst_in;
   logic               mark_hit_ff, mark_hit_in;
   logic               phase2_ff, phase2_in;
   logic [IDX_W-1:0]   nb_ff, nb_in;
   logic [IDX_W-1:0]   acked_ff, acked_in;
   logic [PROD_W-1:0]  ssprod_ff, ssprod_in;
   logic [DIV_NUM_W-1:0] q_ff, q_in;
   logic [WIN_W-1:0]   acc_ff, acc_in;
   logic               acc_sat_ff, acc_sat_in;
   logic [4:0]         bit_ff, bit_in;
   logic [SLOT_W-1:0]  clr_ff, clr_in;

   logic               sent_ff, sent_in;
   logic [IDX_W-1:0]   off_ff, off_in;
   logic [SEG_W-1:0]   len_ff, len_in;
   logic               retx_ff, retx_in;
   event_type          ev_ff, ev_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   logic               mem_we;
   logic [SLOT_W-1:0]  mem_waddr, mem_raddr;
   mark_type           mem_wdata, mem_rdata;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   logic [SEG_W-1:0]   seg_eff;
   logic [RTO_W-1:0]   rto_eff;
   logic [WIN_W-1:0]   seg_fx, seg2_fx, seg3_fx;
   logic [IDX_W-1:0]   base_p1;
   logic               finished;

   logic [IDX_W-1:0]   end_b, len_full, covered, nb_cand;
   logic [WIN_W-1:0]   half_w, nw, ss_inc;
   logic [WIN_W:0]     infl_sum;
   logic [RTO_W-1:0]   el_new;
   logic [DUP_W-1:0]   dup_new;
   logic [21:0]        seg_sq;
   logic [PROD_W-1:0]  total_ext;
   logic [53:0]        mac;
   logic               can_send;

   rcws_ram #(.WIDTH(MARK_W), .DEPTH(WINDOW_SEGMENTS)) u_marks (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   rcws_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign seg_eff  = (seg_size_ff == '0 || seg_size_ff > SEG_W'(MAX_SEGMENT)) ?
                     SEG_W'(MAX_SEGMENT) : seg_size_ff;
   assign rto_eff  = (rto_ff < RTO_W'(MIN_RTO)) ? RTO_W'(MIN_RTO) : rto_ff;
   assign seg_fx   = WIN_W'(seg_eff) << FRAC_W;
   assign seg2_fx  = seg_fx << 1;
   assign seg3_fx  = seg2_fx + seg_fx;
   assign base_p1  = base_ff + 1'b1;
   assign finished = base_ff >= cnt_ff;
   assign total_ext = PROD_W'(total_ff);

   // configuration registers
   always_comb begin
      seg_size_in = seg_size_ff;
      rto_in      = rto_ff;
      total_in    = total_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SEGMENT_SIZE:    seg_size_in = csr_wdata[SEG_W-1:0];
            CSR_RETRANS_TIMEOUT: rto_in      = csr_wdata[RTO_W-1:0];
            CSR_TOTAL_LENGTH:    total_in    = csr_wdata[IDX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      thresh_in    = thresh_ff;
      base_in      = base_ff;
      next_in      = next_ff;
      last_ack_in  = last_ack_ff;
      dup_in       = dup_ff;
      recov_in     = recov_ff;
      timer_in     = timer_ff;
      elapsed_in   = elapsed_ff;
      cnt_in       = cnt_ff;
      kind_in      = kind_ff;
      ack_in       = ack_ff;
      prod_next_in = prod_next_ff;
      prod_base_in = prod_base_ff;
      outst_in     = outst_ff;
      mark_hit_in  = mark_hit_ff;
      phase2_in    = phase2_ff;
      nb_in        = nb_ff;
      acked_in     = acked_ff;
      ssprod_in    = ssprod_ff;
      q_in         = q_ff;
      acc_in       = acc_ff;
      acc_sat_in   = acc_sat_ff;
      bit_in       = bit_ff;
      clr_in       = clr_ff;
      sent_in      = sent_ff;
      off_in       = off_ff;
      len_in       = len_ff;
      retx_in      = retx_ff;
      ev_in        = ev_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      req_tready   = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = next_ff[SLOT_W-1:0];
      mem_wdata    = '{valid: 1'b0, tag: '0};
      mem_raddr    = next_ff[SLOT_W-1:0];
      div_req      = '{start: 1'b0, num: '0, den: '0};

      end_b    = (prod_next_ff > total_ext) ? total_ff : prod_next_ff[IDX_W-1:0];
      len_full = '0;
      covered  = (ack_ff >= total_ff) ? cnt_ff : div_rsp.quo[IDX_W-1:0];
      nb_cand  = (covered > base_ff) ? covered : base_ff;
      half_w   = window_ff >> 1;
      infl_sum = {1'b0, WIN_W'(outst_ff) << FRAC_W} + {1'b0, seg3_fx};
      nw       = (outst_ff != '0) ? (infl_sum[WIN_W] ? WIN_MAX : infl_sum[WIN_W-1:0])
                                  : thresh_ff;
      ss_inc   = (ssprod_ff[PROD_W-1:IDX_W] != '0) ? WIN_MAX :
                 {ssprod_ff[IDX_W-1:0], {FRAC_W{1'b0}}};
      el_new   = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;
      dup_new  = (dup_ff == DUP_MAX) ? dup_ff : dup_ff + 1'b1;
      seg_sq   = {11'b0, seg_eff} * {11'b0, seg_eff};
      mac      = {5'b0, acc_ff, 1'b0} + (acked_ff[bit_ff] ? {1'b0, q_ff} : 54'd0);
      can_send = (next_ff < cnt_ff) && ((next_ff - base_ff) < IDX_W'(WINDOW_SEGMENTS)) &&
                 (outst_ff < window_ff[WIN_W-1:FRAC_W]);

      unique case (state_ff)
         S_RESTART: begin
            window_in   = seg_fx;
            thresh_in   = INIT_THRESH_FX;
            base_in     = '0;
            next_in     = '0;
            last_ack_in = '0;
            dup_in      = '0;
            recov_in    = 1'b0;
            timer_in    = 1'b0;
            elapsed_in  = '0;
            clr_in      = '0;
            div_req     = '{start: 1'b1, num: DIV_NUM_W'(total_ff - 1'b1),
                            den: DIV_DEN_W'(seg_eff)};
            state_in    = S_CLEAR;
         end
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == SLOT_W'(WINDOW_SEGMENTS - 1)) begin
               state_in = S_COUNT;
            end
         end
         S_COUNT: begin
            if (!div_rsp.busy) begin
               cnt_in   = (total_ff == '0) ? '0 : div_rsp.quo[IDX_W-1:0] + 1'b1;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               kind_in   = kind_type'(req_tuser);
               ack_in    = req_tdata;
               phase2_in = 1'b0;
               sent_in   = 1'b0;
               off_in    = '0;
               len_in    = '0;
               retx_in   = 1'b0;
               ev_in     = EV_NONE;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            // mark of next_index comes back with the products
            prod_next_in = {{SEG_W{1'b0}}, next_ff} * {{IDX_W{1'b0}}, seg_eff};
            prod_base_in = {{SEG_W{1'b0}}, base_ff} * {{IDX_W{1'b0}}, seg_eff};
            state_in     = S_OUTST;
         end
         S_OUTST: begin
            outst_in    = (prod_base_ff >= PROD_W'(end_b)) ? '0 :
                          end_b - prod_base_ff[IDX_W-1:0];
            mark_hit_in = mem_rdata.valid && (mem_rdata.tag == next_ff);
            state_in    = phase2_ff ? S_RECOV : S_DISPATCH;
         end
         S_DISPATCH: begin
            state_in = S_RESULT;
            if (!finished) begin
               unique case (kind_ff)
                  KIND_POLL: begin
                     if (can_send) begin
                        if (!mark_hit_ff) begin
                           mem_we    = 1'b1;
                           mem_wdata = '{valid: 1'b1, tag: next_ff};
                           sent_in   = 1'b1;
                           off_in    = prod_next_ff[IDX_W-1:0];
                           len_full  = total_ff - prod_next_ff[IDX_W-1:0];
                           len_in    = (len_full > IDX_W'(seg_eff)) ? seg_eff :
                                       len_full[SEG_W-1:0];
                        end
                        if (!timer_ff) begin
                           timer_in   = 1'b1;
                           elapsed_in = '0;
                        end
                        next_in = next_ff + 1'b1;
                     end
                  end
                  KIND_ACK: begin
                     if (ack_ff > last_ack_ff) begin
                        div_req  = '{start: 1'b1, num: DIV_NUM_W'(ack_ff),
                                     den: DIV_DEN_W'(seg_eff)};
                        state_in = S_ADIV;
                     end else if (ack_ff == last_ack_ff) begin
                        ev_in  = EV_DUP_ACK;
                        dup_in = dup_new;
                        if (recov_ff) begin
                           window_in = sat_add(window_ff, seg_fx);
                        end else if (dup_new >= FAST_RETX_DUPS) begin
                           ev_in     = EV_FAST_RETX;
                           thresh_in = (half_w < seg_fx) ? seg_fx : half_w;
                           state_in  = S_FRT;
                        end
                     end
                  end
                  KIND_TICK: begin
                     if (timer_ff) begin
                        elapsed_in = el_new;
                        if (el_new >= rto_eff) begin
                           ev_in     = EV_TIMEOUT;
                           thresh_in = (half_w <= seg_fx) ? seg2_fx : half_w;
                           window_in = seg_fx;
                           recov_in  = 1'b0;
                           if (base_p1 < cnt_ff) begin
                              mem_we    = 1'b1;
                              mem_waddr = base_p1[SLOT_W-1:0];
                           end
                           state_in = S_RESEND;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_FRT: begin
            // threshold is at most half the window or one segment, so this never wraps
            window_in = thresh_ff + seg3_fx;
            recov_in  = 1'b1;
            state_in  = S_RESEND;
         end
         S_RESEND: begin
            mem_we     = 1'b1;
            mem_waddr  = base_ff[SLOT_W-1:0];
            mem_wdata  = '{valid: 1'b1, tag: base_ff};
            sent_in    = 1'b1;
            retx_in    = 1'b1;
            off_in     = prod_base_ff[IDX_W-1:0];
            len_full   = total_ff - prod_base_ff[IDX_W-1:0];
            len_in     = (len_full > IDX_W'(seg_eff)) ? seg_eff : len_full[SEG_W-1:0];
            next_in    = base_p1;
            timer_in   = 1'b1;
            elapsed_in = '0;
            dup_in     = '0;
            state_in   = S_RESULT;
         end
         S_ADIV: begin
            if (!div_rsp.busy) begin
               state_in = S_ADONE;
            end
         end
         S_ADONE: begin
            nb_in    = nb_cand;
            state_in = S_ACKUPD;
         end
         S_ACKUPD: begin
            // marks of passed segments go stale: their tags fall below base
            acked_in    = nb_ff - base_ff;
            base_in     = nb_ff;
            next_in     = (next_ff < nb_ff) ? nb_ff : next_ff;
            last_ack_in = ack_ff;
            ev_in       = EV_NEW_ACK;
            if (recov_ff) begin
               phase2_in = 1'b1;
               state_in  = S_MUL;
            end else if (window_ff < thresh_ff) begin
               state_in = S_SSMUL;
            end else begin
               state_in = S_CASTART;
            end
         end
         S_RECOV: begin
            window_in = (nw < thresh_ff) ? thresh_ff : nw;
            recov_in  = 1'b0;
            dup_in    = '0;
            phase2_in = 1'b0;
            state_in  = S_CASTART;
         end
         S_SSMUL: begin
            ssprod_in = {{IDX_W{1'b0}}, seg_eff} * {{SEG_W{1'b0}}, acked_ff};
            state_in  = S_SSADD;
         end
         S_SSADD: begin
            window_in = sat_add(window_ff, ss_inc);
            state_in  = S_ACKEND;
         end
         S_CASTART: begin
            div_req  = '{start: 1'b1, num: {seg_sq[20:0], 32'b0},
                         den: (window_ff == '0) ? DIV_DEN_W'(1) : window_ff};
            state_in = S_CADIV;
         end
         S_CADIV: begin
            if (!div_rsp.busy) begin
               q_in       = div_rsp.quo;
               acc_in     = '0;
               acc_sat_in = 1'b0;
               bit_in     = '1;
               state_in   = S_CAMUL;
            end
         end
         S_CAMUL: begin
            // quotient times acked, MSB first, saturating once past 48 bits
            acc_in     = mac[WIN_W-1:0];
            acc_sat_in = acc_sat_ff || (mac[53:WIN_W] != '0);
            bit_in     = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               state_in = S_CAADD;
            end
         end
         S_CAADD: begin
            window_in = sat_add(window_ff, acc_sat_ff ? WIN_MAX : acc_ff);
            state_in  = S_ACKEND;
         end
         S_ACKEND: begin
            if (base_ff == next_ff) begin
               timer_in = 1'b0;
            end else begin
               timer_in   = 1'b1;
               elapsed_in = '0;
            end
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b0, finished, recov_ff,
                               thresh_ff[WIN_W-1:FRAC_W], window_ff[WIN_W-1:FRAC_W],
                               len_ff, off_ff};
               rsp_user_in  = {ev_ff, retx_ff, sent_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_RESTART;
      endcase

      if (csr_we && csr_index <= CSR_TOTAL_LENGTH) begin
         state_in = S_RESTART;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RESTART;
         rsp_valid_ff <= 1'b0;
         seg_size_ff  <= SEG_W'(MAX_SEGMENT);
         rto_ff       <= RTO_W'(200);
         total_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         seg_size_ff  <= seg_size_in;
         rto_ff       <= rto_in;
         total_ff     <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff    <= window_in;
      thresh_ff    <= thresh_in;
      base_ff      <= base_in;
      next_ff      <= next_in;
      last_ack_ff  <= last_ack_in;
      dup_ff       <= dup_in;
      recov_ff     <= recov_in;
      timer_ff     <= timer_in;
      elapsed_ff   <= elapsed_in;
      cnt_ff       <= cnt_in;
      kind_ff      <= kind_in;
      ack_ff       <= ack_in;
      prod_next_ff <= prod_next_in;
      prod_base_ff <= prod_base_in;
      outst_ff     <= outst_in;
      mark_hit_ff  <= mark_hit_in;
      phase2_ff    <= phase2_in;
      nb_ff        <= nb_in;
      acked_ff     <= acked_in;
      ssprod_ff    <= ssprod_in;
      q_ff         <= q_in;
      acc_ff       <= acc_in;
      acc_sat_ff   <= acc_sat_in;
      bit_ff       <= bit_in;
      clr_ff       <= clr_in;
      sent_ff      <= sent_in;
      off_ff       <= off_in;
      len_ff       <= len_in;
      retx_ff      <= retx_in;
      ev_ff        <= ev_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_cursor_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> next_ff >= base_ff)
      else $error("send cursor behind base");

   a_cursor_span: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> (next_ff - base_ff) <= IDX_W'(WINDOW_SEGMENTS))
      else $error("outstanding span beyond mark memory");

   // a restart may abort a count division still running
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_req.start && state_ff != S_RESTART |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_window_floor: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> window_ff >= seg_fx)
      else $error("window below one segment");
endmodule
